[hw/rtl/tsp_pkg.sv]
`default_nettype none

package tsp_pkg;

  // field and register widths
  localparam int unsigned HEIGHT_W       = 32;
  localparam int unsigned SPACING_W      = 31;
  localparam int unsigned COUNT_W        = 13;
  localparam int unsigned PLANE_W        = 12;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned MAX_PLANES_DEF = 4096;

  // register values after reset
  localparam logic signed [HEIGHT_W-1:0] BASE_RST    = '0;
  localparam logic [SPACING_W-1:0]       SPACING_RST = 31'd65536;
  localparam logic [COUNT_W-1:0]         COUNT_RST   = 13'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_HEIGHT   = 2'd0,
    CFG_PLANE_SPACING = 2'd1,
    CFG_PLANE_COUNT   = 2'd2
  } cfg_idx_e;

  // one triangle request
  typedef struct packed {
    logic signed [HEIGHT_W-1:0] vertex_a_height;
    logic signed [HEIGHT_W-1:0] vertex_b_height;
    logic signed [HEIGHT_W-1:0] vertex_c_height;
  } tri_in_t;

  // one binning result
  typedef struct packed {
    logic               hit;
    logic [PLANE_W-1:0] first_plane;
    logic [PLANE_W-1:0] last_plane;
  } bin_out_t;

  // side flags that travel with the divider lanes
  typedef struct packed {
    logic kill;
    logic lo_pos;
    logic lo_zero;
    logic hi_neg;
    logic lo_ne_mid;
    logic hi_ne_mid;
  } bin_flags_t;

endpackage

`default_nettype wire

[hw/rtl/triangle_slice_plane_range.sv]
`default_nettype none

// Bins one triangle per request into evenly spaced slicing planes and returns a hit flag
// with the inclusive range of plane indices crossed. A new triangle can be taken in every
// cycle while the skid stage is empty. Each result is computed by two restoring dividers
// (floor of the lowest and highest vertex offsets over the spacing) that resolve one
// quotient bit per pipeline stage, after a saturation check that pins the quotient to
// all ones when it would not fit in QW = clog2(MAX_PLANES)+1 bits. An output register
// and a one-entry skid stage sit at the end, so one more result is held while the
// output waits; in_ready_o drops while the skid stage is full. Configuration writes
// are taken at any time but must only be made while no request is in flight; the
// plane count reaches the pipeline through the registered nm1_q and prod_q.
module triangle_slice_plane_range
  import tsp_pkg::*;
#(
  parameter int unsigned MAX_PLANES = MAX_PLANES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tri_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bin_out_t              out_data_o
);

  localparam int unsigned IW     = $clog2(MAX_PLANES);
  localparam int unsigned QW     = IW + 1;
  localparam int unsigned PRW    = IW + SPACING_W;
  localparam int unsigned CW     = QW + SPACING_W;
  localparam int unsigned DW     = HEIGHT_W + 1;
  localparam int unsigned NP     = QW + 5;
  localparam int unsigned ST_F1  = NP - 1;

  // configuration registers
  logic signed [HEIGHT_W-1:0] base_q;
  logic [SPACING_W-1:0]       spacing_q;
  logic [COUNT_W-1:0]         count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_RST;
      spacing_q <= SPACING_RST;
      count_q   <= COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE_HEIGHT:   base_q    <= cfg_data_i;
        CFG_PLANE_SPACING: spacing_q <= cfg_data_i[SPACING_W-1:0];
        CFG_PLANE_COUNT:   count_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // plane count clamped to the usable range, and height of the top plane over base
  logic [31:0]    n_w;
  logic [IW-1:0]  nm1_d, nm1_q;
  logic [PRW-1:0] prod_d, prod_q;

  always_comb begin
    n_w = (count_q == '0) ? 32'd1 : 32'(count_q);
    if (n_w > 32'(MAX_PLANES)) begin
      n_w = 32'(MAX_PLANES);
    end
    nm1_d = IW'(n_w - 32'd1);
  end

  assign prod_d = PRW'(nm1_q) * PRW'(spacing_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q  <= '0;
      prod_q <= '0;
    end else begin
      nm1_q  <= nm1_d;
      prod_q <= prod_d;
    end
  end

  // pipeline advance and valid bits
  logic          pipe_en;
  logic          produce;
  logic [NP-1:0] vld_q;
  logic          out_vld_q, skid_vld_q;

  assign pipe_en    = !skid_vld_q;
  assign in_ready_o = pipe_en;
  assign produce    = pipe_en && vld_q[ST_F1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NP-2:0], in_valid_i};
    end
  end

  // stage 1: sort the vertex heights with parallel compares
  logic signed [HEIGHT_W-1:0] va, vb, vc;
  logic signed [HEIGHT_W-1:0] lo_d, mid_d, hi_d;
  logic signed [HEIGHT_W-1:0] lo1_q, mid1_q, hi1_q;

  always_comb begin
    va = in_data_i.vertex_a_height;
    vb = in_data_i.vertex_b_height;
    vc = in_data_i.vertex_c_height;
    lo_d = (va <= vb && va <= vc) ? va : ((vb <= vc) ? vb : vc);
    hi_d = (va >= vb && va >= vc) ? va : ((vb >= vc) ? vb : vc);
    if ((va >= vb && va <= vc) || (va >= vc && va <= vb)) begin
      mid_d = va;
    end else if ((vb >= va && vb <= vc) || (vb >= vc && vb <= va)) begin
      mid_d = vb;
    end else begin
      mid_d = vc;
    end
  end

  // stage 2: offsets from plane zero
  logic signed [DW-1:0] dlo_d, dmid_d, dhi_d;
  logic signed [DW-1:0] dlo2_q, dmid2_q, dhi2_q;
  logic                 flat2_q, lnm2_q, hnm2_q;

  assign dlo_d  = DW'(lo1_q)  - DW'(base_q);
  assign dmid_d = DW'(mid1_q) - DW'(base_q);
  assign dhi_d  = DW'(hi1_q)  - DW'(base_q);

  // stage 3: skip rules and divider operands
  logic                below, above;
  bin_flags_t          fl3_d, fl3_q;
  logic [HEIGHT_W-1:0] a3_d, b3_d, a3_q, b3_q;

  always_comb begin
    below = (dhi2_q[DW-1] || dhi2_q == '0) && dmid2_q[DW-1];
    above = !dlo2_q[DW-1] && !dmid2_q[DW-1]
            && (PRW'(dlo2_q[HEIGHT_W-1:0]) >= prod_q)
            && (PRW'(dmid2_q[HEIGHT_W-1:0]) > prod_q);
    fl3_d.kill      = (spacing_q == '0) || below || above || flat2_q;
    fl3_d.lo_pos    = !dlo2_q[DW-1] && (dlo2_q != '0);
    fl3_d.lo_zero   = (dlo2_q == '0);
    fl3_d.hi_neg    = dhi2_q[DW-1];
    fl3_d.lo_ne_mid = lnm2_q;
    fl3_d.hi_ne_mid = hnm2_q;
    // ceiling of x over s is one more than the floor of x-1 over s
    a3_d = fl3_d.lo_pos ? (dlo2_q[HEIGHT_W-1:0] - 32'd1) : '0;
    b3_d = fl3_d.hi_neg ? '0 : dhi2_q[HEIGHT_W-1:0];
  end

  // divider lanes: index 0 after the saturation check, index i after i quotient bits
  logic [QW-1:0]       qa_q [QW+1];
  logic [QW-1:0]       qb_q [QW+1];
  logic [HEIGHT_W-1:0] ra_q [QW+1];
  logic [HEIGHT_W-1:0] rb_q [QW+1];
  logic                sata_q [QW+1];
  logic                satb_q [QW+1];
  bin_flags_t          fl_q [QW+1];

  logic [QW-1:0]       qa_n [QW+1];
  logic [QW-1:0]       qb_n [QW+1];
  logic [HEIGHT_W-1:0] ra_n [QW+1];
  logic [HEIGHT_W-1:0] rb_n [QW+1];
  logic                sata_d, satb_d;
  logic [CW-1:0]       sat_lim;

  // saturation check: quotient would not fit, so it is pinned to all ones
  assign sat_lim = CW'(spacing_q) << QW;
  assign sata_d  = CW'(a3_q) >= sat_lim;
  assign satb_d  = CW'(b3_q) >= sat_lim;

  // one restoring step per stage, both lanes side by side
  always_comb begin
    logic [CW-1:0] trial;
    logic          take_a, take_b;
    qa_n[0] = '0;
    qb_n[0] = '0;
    ra_n[0] = '0;
    rb_n[0] = '0;
    for (int i = 1; i <= QW; i++) begin
      trial  = CW'(spacing_q) << (QW - i);
      take_a = !sata_q[i-1] && (CW'(ra_q[i-1]) >= trial);
      take_b = !satb_q[i-1] && (CW'(rb_q[i-1]) >= trial);
      ra_n[i] = take_a ? (ra_q[i-1] - trial[HEIGHT_W-1:0]) : ra_q[i-1];
      rb_n[i] = take_b ? (rb_q[i-1] - trial[HEIGHT_W-1:0]) : rb_q[i-1];
      qa_n[i] = qa_q[i-1] | (take_a ? (QW'(1) << (QW - i)) : '0);
      qb_n[i] = qb_q[i-1] | (take_b ? (QW'(1) << (QW - i)) : '0);
    end
  end

  // final stage 1: clamp the indices and find the tip cases
  logic [QW-1:0]       qa_f, qb_f, nm1_w;
  logic [HEIGHT_W-1:0] ra_f, rb_f;
  bin_flags_t          fl_f;
  logic [IW-1:0]       first1_d, last1_d, first1_q, last1_q;
  logic                tip_lo, tip_hi, up1_d, dn1_d, up1_q, dn1_q, kill1_q;

  always_comb begin
    qa_f  = qa_q[QW];
    qb_f  = qb_q[QW];
    ra_f  = ra_q[QW];
    rb_f  = rb_q[QW];
    fl_f  = fl_q[QW];
    nm1_w = QW'(nm1_q);
    if (!fl_f.lo_pos) begin
      first1_d = '0;
    end else if (qa_f >= nm1_w) begin
      first1_d = nm1_q;
    end else begin
      first1_d = IW'(qa_f) + IW'(1);
    end
    if (fl_f.hi_neg) begin
      last1_d = '0;
    end else if (qb_f > nm1_w) begin
      last1_d = nm1_q;
    end else begin
      last1_d = IW'(qb_f);
    end
    // a plane lies exactly on the lowest or highest vertex
    tip_lo = fl_f.lo_zero
             || (fl_f.lo_pos && (qa_f < nm1_w) && (ra_f == (32'(spacing_q) - 32'd1)));
    tip_hi = !fl_f.hi_neg && (qb_f <= nm1_w) && (rb_f == '0);
    up1_d  = tip_lo && fl_f.lo_ne_mid;
    dn1_d  = !up1_d && tip_hi && fl_f.hi_ne_mid;
  end

  // final stage 2: apply the tip rules and the empty-range check
  bin_out_t      res_d;
  logic          res_hit;
  logic [IW-1:0] first_adj, last_adj;

  always_comb begin
    res_hit   = !kill1_q && ((up1_q || dn1_q) ? (first1_q < last1_q) : (first1_q <= last1_q));
    first_adj = first1_q + IW'(up1_q);
    last_adj  = last1_q - IW'(dn1_q);
    res_d.hit         = res_hit;
    res_d.first_plane = res_hit ? PLANE_W'(first_adj) : '0;
    res_d.last_plane  = res_hit ? PLANE_W'(last_adj) : '0;
  end

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lo1_q   <= lo_d;
      mid1_q  <= mid_d;
      hi1_q   <= hi_d;
      dlo2_q  <= dlo_d;
      dmid2_q <= dmid_d;
      dhi2_q  <= dhi_d;
      flat2_q <= (lo1_q == hi1_q);
      lnm2_q  <= (lo1_q != mid1_q);
      hnm2_q  <= (hi1_q != mid1_q);
      fl3_q   <= fl3_d;
      a3_q    <= a3_d;
      b3_q    <= b3_d;
      qa_q[0]   <= {QW{sata_d}};
      qb_q[0]   <= {QW{satb_d}};
      ra_q[0]   <= a3_q;
      rb_q[0]   <= b3_q;
      sata_q[0] <= sata_d;
      satb_q[0] <= satb_d;
      fl_q[0]   <= fl3_q;
      for (int i = 1; i <= QW; i++) begin
        qa_q[i]   <= qa_n[i];
        qb_q[i]   <= qb_n[i];
        ra_q[i]   <= ra_n[i];
        rb_q[i]   <= rb_n[i];
        sata_q[i] <= sata_q[i-1];
        satb_q[i] <= satb_q[i-1];
        fl_q[i]   <= fl_q[i-1];
      end
      first1_q <= first1_d;
      last1_q  <= last1_d;
      up1_q    <= up1_d;
      dn1_q    <= dn1_d;
      kill1_q  <= fl_f.kill;
    end
  end

  // output register with a one-entry skid stage behind it
  bin_out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q  <= skid_vld_q || produce;
      skid_vld_q <= 1'b0;
    end else if (produce) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (produce) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
